/* hw/rtl/bls_pkg.sv */
`default_nettype none
package bls_pkg;
    localparam int TAPS         = 17;
    localparam int PHASES       = 32;
    localparam int ROW_STRIDE   = 32;
    localparam int CHANNELS     = 2;
    localparam int RING_DEPTH   = 64;
    localparam int KERNEL_DEPTH = PHASES * ROW_STRIDE;
    localparam int TAPS_CAP     = (TAPS < ROW_STRIDE) ? TAPS : ROW_STRIDE;

    localparam int KADDR_W  = $clog2(KERNEL_DEPTH);
    localparam int RING_W   = $clog2(RING_DEPTH);
    localparam int RADDR_W  = RING_W + 1;
    localparam int PH_IDX_W = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int TAP_W    = 5;
    localparam int PHREG_W  = 6;
    localparam int LVL_W    = 16;
    localparam int ACC_W    = 24;
    localparam int CFG_W    = 16;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SYNTH  = 2'd1,
        ACT_RENDER = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    localparam logic [1:0] CFG_ALPHA  = 2'd0;
    localparam logic [1:0] CFG_CHANS  = 2'd1;
    localparam logic [1:0] CFG_PHASES = 2'd2;
    localparam logic [1:0] CFG_TAPS   = 2'd3;

    localparam logic [15:0]        RST_ALPHA  = 16'd65506;
    localparam logic [1:0]         RST_CHANS  = 2'd2;
    localparam logic [PHREG_W-1:0] RST_PHASES = 6'd22;
    localparam logic [TAP_W-1:0]   RST_TAPS   = 5'd17;

    typedef struct packed {
        logic latch;
        logic kload;
        logic synth_prep;
        logic tap_issue;
        logic rd_issue;
        logic r_acc;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_action action;
        logic    ch_ok;
        logic    wr_ok;
        logic    tap_last;
        logic    pipe_busy;
        logic    out_free;
    } t_dp_stat;
endpackage
`default_nettype wire

/* hw/rtl/bls_in_if.sv */
`default_nettype none
interface bls_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [9:0]         coef_index;
    logic signed [15:0] coef_value;
    logic [5:0]         sample_offset;
    logic [15:0]        fraction;
    logic               channel;
    logic signed [15:0] level;
    logic               is_eight_bit;
    logic signed [15:0] mix_in;
    logic               last_channel;

    modport source (output valid, action, coef_index, coef_value, sample_offset, fraction,
                    channel, level, is_eight_bit, mix_in, last_channel, input ready);
    modport sink (input valid, action, coef_index, coef_value, sample_offset, fraction,
                  channel, level, is_eight_bit, mix_in, last_channel, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bls_out_if.sv */
`default_nettype none
interface bls_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               out_channel;

    modport source (output valid, sample, out_channel, input ready);
    modport sink (input valid, sample, out_channel, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bls_ctrl.sv */
`default_nettype none
module bls_ctrl
    import bls_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_TAP,
        S_DRAIN,
        S_RACC,
        S_ROUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = i_rst_n;
                if (i_valid && i_rst_n) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.action)
                    ACT_LOAD: o_cmd.kload = 1'b1;
                    ACT_SYNTH: begin
                        if (i_stat.ch_ok && i_stat.wr_ok) begin
                            o_cmd.synth_prep = 1'b1;
                            n_state          = S_TAP;
                        end
                    end
                    ACT_RENDER: begin
                        if (i_stat.ch_ok) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_RACC;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TAP: begin
                o_cmd.tap_issue = 1'b1;
                if (i_stat.tap_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = S_IDLE;
            end
            S_RACC: begin
                o_cmd.r_acc = 1'b1;
                n_state     = S_ROUT;
            end
            S_ROUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/bls_dp.sv */
`default_nettype none
module bls_dp
    import bls_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_addr,
    input  wire logic [CFG_W-1:0]   i_cfg_wdata,
    input  wire logic [1:0]         i_action,
    input  wire logic [9:0]         i_coef_index,
    input  wire logic signed [15:0] i_coef_value,
    input  wire logic [5:0]         i_sample_offset,
    input  wire logic [15:0]        i_fraction,
    input  wire logic               i_channel,
    input  wire logic signed [15:0] i_level,
    input  wire logic               i_is_eight_bit,
    input  wire logic signed [15:0] i_mix_in,
    input  wire logic               i_last_channel,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic signed [15:0]      o_sample,
    output logic                    o_out_channel,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_stat                o_stat
);
    logic [15:0]        r_alpha;
    logic [1:0]         r_chans;
    logic [PHREG_W-1:0] r_phases;
    logic [TAP_W-1:0]   r_taps;

    logic [1:0]               r_action;
    logic [9:0]               r_coef_index;
    logic signed [15:0]       r_coef_value;
    logic [RING_W-1:0]        r_offset;
    logic [15:0]              r_frac;
    logic                     r_ch;
    logic signed [LVL_W-1:0]  r_level;
    logic                     r_eight;
    logic signed [15:0]       r_mix;
    logic                     r_last;

    logic signed [LVL_W-1:0] r_prior [CHANNELS];
    logic signed [ACC_W-1:0] r_integ [CHANNELS];
    logic [RING_W-1:0]       r_pos;

    logic [PH_IDX_W-1:0]     r_phase;
    logic [TAP_W-1:0]        r_taps_eff;
    logic [TAP_W-1:0]        r_tap;
    logic signed [LVL_W:0]   r_change;

    logic signed [15:0]      kmem [KERNEL_DEPTH];
    logic signed [15:0]      r_kern_rd;
    logic signed [ACC_W-1:0] rmem [2*RING_DEPTH];
    logic signed [ACC_W-1:0] r_ring_rd;
    logic                    r_rvld [2*RING_DEPTH];
    logic                    r_ring_vld_rd;

    logic                    r_s1_vld, r_s2_vld;
    logic [RING_W-1:0]       r_s1_slot, r_s2_slot;
    logic signed [32:0]      r_mprod;
    logic signed [ACC_W-1:0] r_s2_acc;
    logic signed [40:0]      r_iprod;
    logic signed [ACC_W-1:0] r_y;
    logic                    r_out_vld;
    logic signed [15:0]      r_sample;
    logic                    r_out_ch;

    logic [1:0]              act_ch;
    logic                    ch_ok;
    logic [TAP_W-1:0]        taps_odd, taps_eff;
    logic                    wr_ok;
    logic [PHREG_W-1:0]      phases_eff;
    logic [15+PHREG_W:0]     phase_prod;
    logic signed [LVL_W-1:0] lvl;
    logic [KADDR_W-1:0]      k_addr;
    logic [RING_W-1:0]       tap_slot;
    logic [RADDR_W-1:0]      rd_addr, wr_addr, rend_addr;
    logic signed [ACC_W-1:0] ring_eff;
    logic signed [32:0]      rnd;
    logic signed [17:0]      addv;
    logic signed [ACC_W-1:0] acc_new;
    logic signed [40:0]      irnd;
    logic signed [ACC_W:0]   yq;
    logic signed [ACC_W-1:0] y_new;
    logic signed [ACC_W:0]   smix;
    logic signed [15:0]      s_new;
    logic                    out_free;

    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W+1:0] hi, lo;
        hi = (ACC_W+2)'(2**(ACC_W-1) - 1);
        lo = -(ACC_W+2)'(2**(ACC_W-1));
        if (v > hi) return hi[ACC_W-1:0];
        else if (v < lo) return lo[ACC_W-1:0];
        else return v[ACC_W-1:0];
    endfunction

    assign act_ch     = (r_chans > 2'(CHANNELS)) ? 2'(CHANNELS) : r_chans;
    assign ch_ok      = {1'b0, r_ch} < act_ch;
    assign taps_odd   = r_taps | TAP_W'(1);
    assign taps_eff   = (taps_odd > TAP_W'(TAPS_CAP)) ? TAP_W'(TAPS_CAP) : taps_odd;
    assign wr_ok      = ({1'b0, r_offset} + RADDR_W'(taps_eff)) <= RADDR_W'(RING_DEPTH);
    assign phases_eff = (r_phases == '0) ? PHREG_W'(1) :
                        (r_phases > PHREG_W'(PHASES)) ? PHREG_W'(PHASES) : r_phases;
    assign phase_prod = r_frac * phases_eff;
    assign lvl        = r_eight ? {~r_level[7], r_level[6:0], 8'h00} : r_level;

    assign k_addr    = KADDR_W'(r_phase) * KADDR_W'(ROW_STRIDE) + KADDR_W'(r_tap);
    assign tap_slot  = r_pos + r_offset + RING_W'(r_tap);
    assign rend_addr = {r_pos, r_ch};
    assign rd_addr   = i_cmd.rd_issue ? rend_addr : {tap_slot, r_ch};
    assign wr_addr   = {r_s2_slot, r_ch};
    assign ring_eff  = r_ring_vld_rd ? r_ring_rd : '0;

    assign rnd     = r_mprod[32] ? r_mprod + 33'sd16383 : r_mprod + 33'sd16384;
    assign addv    = 18'(rnd >>> 15);
    assign acc_new = sat_acc((ACC_W+2)'(r_s2_acc) + (ACC_W+2)'(addv));

    assign irnd  = r_iprod[40] ? r_iprod + 41'sd65535 : r_iprod;
    assign yq    = (ACC_W+1)'(irnd >>> 16);
    assign y_new = sat_acc((ACC_W+2)'(yq) + (ACC_W+2)'(ring_eff));

    assign smix  = (ACC_W+1)'(r_mix) + (ACC_W+1)'(r_y);
    assign s_new = (smix > (ACC_W+1)'(32767)) ? 16'sh7FFF :
                   (smix < -(ACC_W+1)'(32768)) ? 16'sh8000 : smix[15:0];

    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        o_stat           = '0;
        o_stat.action    = t_action'(r_action);
        o_stat.ch_ok     = ch_ok;
        o_stat.wr_ok     = wr_ok;
        o_stat.tap_last  = (r_tap == r_taps_eff - TAP_W'(1));
        o_stat.pipe_busy = r_s1_vld || r_s2_vld;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid   = r_out_vld;
    assign o_sample      = r_sample;
    assign o_out_channel = r_out_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= RST_ALPHA;
            r_chans  <= RST_CHANS;
            r_phases <= RST_PHASES;
            r_taps   <= RST_TAPS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ALPHA:  r_alpha  <= i_cfg_wdata;
                CFG_CHANS:  r_chans  <= i_cfg_wdata[1:0];
                CFG_PHASES: r_phases <= i_cfg_wdata[PHREG_W-1:0];
                CFG_TAPS:   r_taps   <= i_cfg_wdata[TAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action     <= i_action;
            r_coef_index <= i_coef_index;
            r_coef_value <= i_coef_value;
            r_offset     <= i_sample_offset;
            r_frac       <= i_fraction;
            r_ch         <= i_channel;
            r_level      <= i_level;
            r_eight      <= i_is_eight_bit;
            r_mix        <= i_mix_in;
            r_last       <= i_last_channel;
        end
        if (i_cmd.synth_prep) begin
            r_phase    <= phase_prod[16 +: PH_IDX_W];
            r_taps_eff <= taps_eff;
            r_change   <= (LVL_W+1)'(lvl) - (LVL_W+1)'(r_prior[r_ch]);
        end
        if (i_cmd.rd_issue) begin
            r_iprod <= $signed({1'b0, r_alpha}) * r_integ[r_ch];
        end
        if (i_cmd.r_acc) begin
            r_y <= y_new;
        end
        r_mprod   <= r_change * r_kern_rd;
        r_s2_acc  <= ring_eff;
        r_s1_slot <= tap_slot;
        r_s2_slot <= r_s1_slot;
        if (i_cmd.out_load) begin
            r_sample <= s_new;
            r_out_ch <= r_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.kload && ({1'b0, r_coef_index} < 11'(KERNEL_DEPTH))) begin
            kmem[r_coef_index[KADDR_W-1:0]] <= r_coef_value;
        end
        r_kern_rd <= kmem[k_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            rmem[wr_addr] <= acc_new;
        end
        r_ring_rd     <= rmem[rd_addr];
        r_ring_vld_rd <= r_rvld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2*RING_DEPTH; i++) r_rvld[i] <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_prior[i] <= '0;
                r_integ[i] <= '0;
            end
            r_pos      <= '0;
            r_tap      <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_s2_vld) r_rvld[wr_addr] <= 1'b1;
            if (i_cmd.r_acc) begin
                r_rvld[rend_addr] <= 1'b0;
                r_integ[r_ch]     <= y_new;
            end
            if (i_cmd.synth_prep) begin
                r_prior[r_ch] <= lvl;
                r_tap         <= '0;
            end else if (i_cmd.tap_issue) begin
                r_tap <= r_tap + TAP_W'(1);
            end
            r_s1_vld <= i_cmd.tap_issue;
            r_s2_vld <= r_s1_vld;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
                if (r_last) r_pos <= r_pos + RING_W'(1);
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    a_s2_follows_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> $past(r_s1_vld))
        else $error("tap pipeline stage 2 without stage 1");
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register overwritten before transaction");
    a_tap_not_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tap_issue |-> !(i_cmd.r_acc || i_cmd.rd_issue || r_out_vld && i_cmd.out_load))
        else $error("synth taps overlap render");
endmodule
`default_nettype wire

/* hw/rtl/band_limited_step_synth.sv */
`default_nettype none
// Channel   Dir  Payload
// i_req     in   action, coef_index, coef_value, sample_offset, fraction,
//                channel, level, is_eight_bit, mix_in, last_channel
// o_rsp     out  sample, out_channel (render transactions only)
// i_cfg_*   in   write enable, register index, 16-bit data
//
// Kernel load: latch, then kernel write. Synth write: latch, decode, taps (made odd
// and capped), one ring slot per cycle through the ring memory, then drain.
// Ignored or dropped items: latch, decode. Render: ring read and integrator multiply,
// accumulate, output. One transaction is in work at a time.
// Synchronous active-low reset clears control, ring valid bits and channel state.
// A stalled output holds its register; the next transaction is still accepted,
// but a following render waits until the held result is taken.
module band_limited_step_synth
    import bls_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    bls_in_if.sink                i_req,
    bls_out_if.source             o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);
    t_dp_cmd  cmd;
    t_dp_stat stat;

    bls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bls_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_req.action),
        .i_coef_index    (i_req.coef_index),
        .i_coef_value    (i_req.coef_value),
        .i_sample_offset (i_req.sample_offset),
        .i_fraction      (i_req.fraction),
        .i_channel       (i_req.channel),
        .i_level         (i_req.level),
        .i_is_eight_bit  (i_req.is_eight_bit),
        .i_mix_in        (i_req.mix_in),
        .i_last_channel  (i_req.last_channel),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_sample        (o_rsp.sample),
        .o_out_channel   (o_rsp.out_channel),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );
endmodule
`default_nettype wire
